### hdl/descriptor_slot_allocator_core_macros.svh
// assertion macros for the descriptor slot allocator
`ifndef DESCRIPTOR_SLOT_ALLOCATOR_CORE_MACROS_SVH
`define DESCRIPTOR_SLOT_ALLOCATOR_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define DSA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define DSA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define DSA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define DSA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

### hdl/dsa_pkg.sv
// ----------------------------------------------------------------------------
// dsa_pkg
// shared types and codes of the descriptor slot allocator
// ----------------------------------------------------------------------------
`default_nettype none
package dsa_pkg;
    localparam logic [1:0] OP_ALLOC_P = 2'd0;
    localparam logic [1:0] OP_FREE_P  = 2'd1;
    localparam logic [1:0] OP_ALLOC_T = 2'd2;
    localparam logic [1:0] OP_LOOKUP  = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_EXHAUST = 3'd1;
    localparam logic [2:0] ST_BAD_IDX = 3'd2;
    localparam logic [2:0] ST_DBL     = 3'd3;
    localparam logic [2:0] ST_ZERO    = 3'd4;
    localparam logic [2:0] ST_SUBMIT  = 3'd5;
    localparam logic [2:0] ST_BAD_FRM = 3'd6;
    localparam logic [2:0] ST_CORRUPT = 3'd7;

    localparam logic [1:0] REG_FRAME_COUNT = 2'd0;
    localparam logic [1:0] REG_DESC_SIZE   = 2'd1;
    localparam logic [1:0] REG_CPU_BASE    = 2'd2;
    localparam logic [1:0] REG_GPU_BASE    = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE, S_CLEAR, S_READ, S_DECIDE, S_DIV, S_TALLOC,
        S_MUL, S_CPU, S_GPU, S_OUT
    } t_state;

    // multiply unit control
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } t_mul_ctl;
endpackage
`default_nettype wire

### hdl/dsa_mul.sv
// ----------------------------------------------------------------------------
// dsa_mul
// shift-add multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none
module dsa_mul #(
    parameter int AW = 16,
    parameter int BW = 16
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_start,
    input  wire  [AW-1:0]   i_a,
    input  wire  [BW-1:0]   i_b,
    output dsa_pkg::t_mul_ctl o_ctl,
    output logic [AW+BW-1:0] o_prod
);
    localparam int CW = $clog2(BW + 1);
    logic [CW-1:0]     r_cnt, n_cnt;
    logic              r_busy, n_busy, r_done, n_done;
    logic [AW+BW-1:0]  r_acc, n_acc, r_a, n_a;
    logic [BW-1:0]     r_b, n_b;

    always_comb begin
        n_cnt = r_cnt; n_busy = r_busy; n_done = 1'b0;
        n_acc = r_acc; n_a = r_a; n_b = r_b;
        if (i_start) begin
            n_cnt = CW'(BW); n_busy = 1'b1; n_acc = '0;
            n_a = (AW+BW)'(i_a); n_b = i_b;
        end else if (r_busy) begin
            if (r_b[0]) n_acc = r_acc + r_a;
            n_a = r_a << 1;
            n_b = r_b >> 1;
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0; n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0; r_cnt <= '0;
        end else begin
            r_busy <= n_busy; r_done <= n_done; r_cnt <= n_cnt;
        end
        r_acc <= n_acc; r_a <= n_a; r_b <= n_b;
    end

    assign o_ctl.start = i_start;
    assign o_ctl.busy  = r_busy;
    assign o_ctl.done  = r_done;
    assign o_prod      = r_acc;
endmodule
`default_nettype wire

### hdl/descriptor_slot_allocator_core.sv
// ----------------------------------------------------------------------------
// descriptor_slot_allocator_core
// persistent free-list/bump allocator and per-frame transient linear allocator
// ----------------------------------------------------------------------------
// channel  dir  handshake            payload
// req      in   i_valid / o_ready    op, slot_index, range_count, frame_index, ...
// rsp      out  o_valid / i_ready    status, slot_out, handles, counters
// cfg      in   apb psel/penable     frame_count, descriptor_size, heap bases
//
// each request passes a register read, for a transient allocate a restoring
// divide of the region by the frame count, then a shared 16x10 shift-add
// multiply and two 64-bit adds; a new request is not taken before the last
// response has been accepted.
// after reset a clearing pass walks the allocated bitmap before the first
// request is taken. the response register holds while i_ready is low.
`default_nettype none
`include "descriptor_slot_allocator_core_macros.svh"
module descriptor_slot_allocator_core #(
    parameter int PERSISTENT_SLOTS = 512,
    parameter int TRANSIENT_SLOTS  = 512,
    parameter int MAX_FRAMES       = 4
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [1:0]  i_op,
    input  wire  [9:0]  i_slot_index,
    input  wire  [9:0]  i_range_count,
    input  wire  [1:0]  i_frame_index,
    input  wire  [63:0] i_fence_value,
    input  wire         i_list_submitted,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [2:0]  o_status,
    output logic [9:0]  o_slot_out,
    output logic [63:0] o_cpu_handle,
    output logic [63:0] o_gpu_handle,
    output logic [8:0]  o_persistent_in_use,
    output logic [8:0]  o_persistent_high_water,
    output logic [9:0]  o_transient_in_use,
    output logic [9:0]  o_transient_high_water,
    output logic [31:0] o_exhaustion_count,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [4:0]  paddr,
    input  wire  [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    localparam int PW  = $clog2(PERSISTENT_SLOTS);
    localparam int FC  = $clog2(PERSISTENT_SLOTS + 1);
    localparam int TW  = $clog2(TRANSIENT_SLOTS + 1);
    localparam int FW  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int QW  = 3;
    localparam int DNW = $clog2(TW + 1);

    // configuration
    logic [2:0]  r_frame_count;
    logic [15:0] r_desc_size;
    logic [63:0] r_cpu_base, r_gpu_base;
    logic        w_cfg_wr;
    logic [1:0]  w_cfg_idx;
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel & penable & pwrite;
    assign w_cfg_idx = paddr[4:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count <= 3'd1; r_desc_size <= 16'd32;
            r_cpu_base <= '0; r_gpu_base <= '0;
        end else if (w_cfg_wr && paddr[2:0] == 3'd0) begin
            case (w_cfg_idx)
                dsa_pkg::REG_FRAME_COUNT: r_frame_count <= pwdata[2:0];
                dsa_pkg::REG_DESC_SIZE:   r_desc_size   <= pwdata[15:0];
                dsa_pkg::REG_CPU_BASE:    r_cpu_base    <= pwdata;
                dsa_pkg::REG_GPU_BASE:    r_gpu_base    <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_cfg_idx)
            dsa_pkg::REG_FRAME_COUNT: prdata = {61'd0, r_frame_count};
            dsa_pkg::REG_DESC_SIZE:   prdata = {48'd0, r_desc_size};
            dsa_pkg::REG_CPU_BASE:    prdata = r_cpu_base;
            dsa_pkg::REG_GPU_BASE:    prdata = r_gpu_base;
            default:                  prdata = '0;
        endcase
    end

    // state
    dsa_pkg::t_state r_state, n_state;
    logic [1:0]  r_op;
    logic [9:0]  r_idx, r_cnt;
    logic [1:0]  r_frm;
    logic [63:0] r_fence;
    logic        r_sub;

    logic [PW-1:0] r_clr;
    logic          r_map_q;
    logic [PW-1:0] r_fifo_q;
    logic [PW-1:0] r_head;
    logic [FC-1:0] r_fill;
    logic [FC-1:0] r_bump;
    logic [TW-1:0] r_cursor [MAX_FRAMES];
    logic [63:0]   r_seen   [MAX_FRAMES];
    logic          r_seen_v [MAX_FRAMES];
    logic [31:0]   r_p_use, r_p_hw, r_t_use, r_t_hw, r_exh;

    logic        r_map [PERSISTENT_SLOTS];
    logic [PW-1:0] r_fifo [PERSISTENT_SLOTS];

    logic [2:0]  r_st;
    logic [9:0]  r_slot;
    logic        r_ovalid;
    logic [63:0] r_cpu, r_gpu;

    // divider state: per = T / fc, rem
    logic [TW-1:0] r_dq, r_dr;
    logic [DNW-1:0] r_dn;
    logic [QW-1:0] r_fc;

    // request sanitized frame count
    logic [QW-1:0] w_fc;
    always_comb begin
        w_fc = r_frame_count;
        if (w_fc == 3'd0) w_fc = 3'd1;
        if (32'(w_fc) > MAX_FRAMES) w_fc = QW'(MAX_FRAMES);
        if (32'(w_fc) > TRANSIENT_SLOTS) w_fc = QW'(TRANSIENT_SLOTS);
    end

    wire w_acc_in  = i_valid & o_ready;
    wire w_acc_out = r_ovalid & i_ready;
    wire [FW-1:0] w_f = FW'(r_frm);

    // multiplier
    dsa_pkg::t_mul_ctl w_mctl;
    logic [25:0] w_prod;
    logic        w_mstart;
    dsa_mul #(.AW(16), .BW(10)) u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_mstart),
        .i_a(r_desc_size), .i_b(r_slot), .o_ctl(w_mctl), .o_prod(w_prod)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            dsa_pkg::S_CLEAR: if (r_clr == PW'(PERSISTENT_SLOTS - 1)) n_state = dsa_pkg::S_IDLE;
            dsa_pkg::S_IDLE:  if (w_acc_in) n_state = dsa_pkg::S_READ;
            dsa_pkg::S_READ:  n_state = (r_op == dsa_pkg::OP_ALLOC_T) ? dsa_pkg::S_DIV
                                                                      : dsa_pkg::S_DECIDE;
            dsa_pkg::S_DIV:   if (r_dn == '0) n_state = dsa_pkg::S_TALLOC;
            dsa_pkg::S_TALLOC: n_state = dsa_pkg::S_MUL;
            dsa_pkg::S_DECIDE: n_state = dsa_pkg::S_MUL;
            dsa_pkg::S_MUL:   if (w_mctl.done) n_state = dsa_pkg::S_CPU;
            dsa_pkg::S_CPU:   n_state = dsa_pkg::S_GPU;
            dsa_pkg::S_GPU:   n_state = dsa_pkg::S_OUT;
            dsa_pkg::S_OUT:   if (w_acc_out) n_state = dsa_pkg::S_IDLE;
            default:          n_state = dsa_pkg::S_IDLE;
        endcase
    end

    // outputs of the sequencer
    // the multiply starts once the slot register holds the decided slot
    always_comb begin
        o_ready  = (r_state == dsa_pkg::S_IDLE);
        w_mstart = (r_state == dsa_pkg::S_MUL) && !w_mctl.busy && !w_mctl.done;
    end

    // transient decision inputs
    logic [TW-1:0] w_cur, w_cap, w_room, w_start;
    logic          w_refresh, w_lt;
    logic [31:0]   w_tuse_ref;
    always_comb begin
        w_refresh = !r_seen_v[w_f] || (r_seen[w_f] != r_fence);
        w_cur = w_refresh ? '0 : r_cursor[w_f];
        w_tuse_ref = r_t_use;
        if (w_refresh && r_seen_v[w_f])
            w_tuse_ref = (r_t_use >= 32'(r_cursor[w_f])) ? r_t_use - 32'(r_cursor[w_f]) : 32'd0;
        w_lt = (TW'(r_frm) < r_dr);
        w_start = TW'(32'(r_frm) * 32'(r_dq)) + (w_lt ? TW'(r_frm) : r_dr);
        w_cap = r_dq + (w_lt ? TW'(1) : TW'(0));
        w_room = (w_cur >= w_cap) ? '0 : w_cap - w_cur;
    end

    logic [FC-1:0] w_pidx;
    logic          w_from_fifo;
    logic          w_palloc_ok;
    assign w_from_fifo = (r_fill != '0);
    assign w_pidx = w_from_fifo ? FC'(r_fifo_q) : r_bump;
    assign w_palloc_ok = !(!w_from_fifo && r_bump >= FC'(PERSISTENT_SLOTS))
                         && !(w_pidx == '0 || w_pidx >= FC'(PERSISTENT_SLOTS) || r_map_q);

    logic [TW:0] w_rsub;
    assign w_rsub = {r_dr[TW-2:0], r_dq[TW-1]} - (TW+1)'(r_fc);

    logic [31:0] w_tsum;
    assign w_tsum = w_tuse_ref + 32'(r_cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dsa_pkg::S_CLEAR;
            r_clr <= '0; r_head <= '0; r_fill <= '0; r_bump <= FC'(1);
            r_p_use <= '0; r_p_hw <= '0; r_t_use <= '0; r_t_hw <= '0; r_exh <= '0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < MAX_FRAMES; i++) begin
                r_cursor[i] <= '0; r_seen[i] <= '0; r_seen_v[i] <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            if (w_acc_out) r_ovalid <= 1'b0;
            case (r_state)
                dsa_pkg::S_CLEAR: r_clr <= r_clr + PW'(1);
                dsa_pkg::S_DECIDE: begin
                    case (r_op)
                        dsa_pkg::OP_ALLOC_P: begin
                            if (!w_from_fifo && r_bump >= FC'(PERSISTENT_SLOTS)) begin
                                r_st <= dsa_pkg::ST_EXHAUST; r_exh <= r_exh + 32'd1;
                            end else if (w_pidx == '0 || w_pidx >= FC'(PERSISTENT_SLOTS)
                                         || r_map_q) begin
                                r_st <= dsa_pkg::ST_CORRUPT;
                            end else begin
                                r_st <= dsa_pkg::ST_OK;
                                r_slot <= 10'(w_pidx);
                                if (w_from_fifo) begin
                                    r_head <= r_head + PW'(1); r_fill <= r_fill - FC'(1);
                                end else r_bump <= r_bump + FC'(1);
                                r_p_use <= r_p_use + 32'd1;
                                if (r_p_use + 32'd1 > r_p_hw) r_p_hw <= r_p_use + 32'd1;
                            end
                        end
                        dsa_pkg::OP_FREE_P: begin
                            r_slot <= r_idx;
                            if (r_idx == '0 || 32'(r_idx) >= PERSISTENT_SLOTS)
                                r_st <= dsa_pkg::ST_BAD_IDX;
                            else if (!r_map_q) r_st <= dsa_pkg::ST_DBL;
                            else if (r_fill >= FC'(PERSISTENT_SLOTS)) r_st <= dsa_pkg::ST_CORRUPT;
                            else begin
                                r_st <= dsa_pkg::ST_OK;
                                r_fill <= r_fill + FC'(1);
                                if (r_p_use != '0) r_p_use <= r_p_use - 32'd1;
                            end
                        end
                        default: begin
                            r_slot <= r_idx;
                            r_st <= (32'(r_idx) < PERSISTENT_SLOTS + TRANSIENT_SLOTS)
                                    ? dsa_pkg::ST_OK : dsa_pkg::ST_BAD_IDX;
                        end
                    endcase
                end
                dsa_pkg::S_TALLOC: begin
                    if (r_cnt == '0) r_st <= dsa_pkg::ST_ZERO;
                    else if (r_sub) r_st <= dsa_pkg::ST_SUBMIT;
                    else if (32'(r_frm) >= 32'(r_fc)) r_st <= dsa_pkg::ST_BAD_FRM;
                    else begin
                        if (w_refresh) begin
                            r_seen[w_f] <= r_fence; r_seen_v[w_f] <= 1'b1;
                        end
                        if (32'(r_cnt) > 32'(w_room)) begin
                            r_st <= dsa_pkg::ST_EXHAUST; r_exh <= r_exh + 32'd1;
                            // the rewind stands even though the request fails
                            if (w_refresh) begin
                                r_cursor[w_f] <= '0; r_t_use <= w_tuse_ref;
                            end
                        end else begin
                            r_st <= dsa_pkg::ST_OK;
                            r_slot <= 10'(PERSISTENT_SLOTS + 32'(w_start) + 32'(w_cur));
                            r_cursor[w_f] <= w_cur + TW'(r_cnt);
                            if (w_tsum > TRANSIENT_SLOTS) begin
                                r_t_use <= 32'(TRANSIENT_SLOTS);
                                if (32'(TRANSIENT_SLOTS) > r_t_hw) r_t_hw <= 32'(TRANSIENT_SLOTS);
                            end else begin
                                r_t_use <= w_tsum;
                                if (w_tsum > r_t_hw) r_t_hw <= w_tsum;
                            end
                        end
                    end
                end
                dsa_pkg::S_GPU: r_ovalid <= 1'b1;
                default: ;
            endcase
        end
    end

    // payload and memories
    always_ff @(posedge i_clk) begin
        if (w_acc_in) begin
            r_op <= i_op; r_idx <= i_slot_index; r_cnt <= i_range_count;
            r_frm <= i_frame_index; r_fence <= i_fence_value; r_sub <= i_list_submitted;
        end
        if (r_state == dsa_pkg::S_CLEAR) r_map[r_clr] <= 1'b0;
        if (r_state == dsa_pkg::S_DECIDE && r_op == dsa_pkg::OP_ALLOC_P
            && w_palloc_ok) r_map[PW'(w_pidx)] <= 1'b1;
        else if (r_state == dsa_pkg::S_DECIDE && r_op == dsa_pkg::OP_FREE_P
                 && r_idx != '0 && 32'(r_idx) < PERSISTENT_SLOTS && r_map_q
                 && r_fill < FC'(PERSISTENT_SLOTS)) begin
            r_map[PW'(r_idx)] <= 1'b0;
            r_fifo[r_head + PW'(r_fill)] <= PW'(r_idx);
        end
        if (r_state == dsa_pkg::S_READ) begin
            r_map_q <= (r_op == dsa_pkg::OP_ALLOC_P) ? r_map[PW'(w_pidx)] : r_map[PW'(r_idx)];
            r_fc <= w_fc;
            r_dq <= TW'(TRANSIENT_SLOTS); r_dr <= '0; r_dn <= DNW'(TW);
        end else if (r_state == dsa_pkg::S_DIV && r_dn != '0) begin
            r_dn <= r_dn - DNW'(1);
            if (!w_rsub[TW]) begin
                r_dr <= w_rsub[TW-1:0]; r_dq <= {r_dq[TW-2:0], 1'b1};
            end else begin
                r_dr <= {r_dr[TW-2:0], r_dq[TW-1]}; r_dq <= {r_dq[TW-2:0], 1'b0};
            end
        end
        if (r_state == dsa_pkg::S_IDLE) r_fifo_q <= r_fifo[r_head];
        if (r_state == dsa_pkg::S_CPU) r_cpu <= (r_st == dsa_pkg::ST_OK)
            ? r_cpu_base + 64'(w_prod) : 64'd0;
        if (r_state == dsa_pkg::S_GPU) r_gpu <= (r_st == dsa_pkg::ST_OK)
            ? r_gpu_base + 64'(w_prod) : 64'd0;
    end

    assign o_valid  = r_ovalid;
    assign o_status = r_st;
    assign o_slot_out = (r_st == dsa_pkg::ST_OK) ? r_slot : 10'd0;
    assign o_cpu_handle = r_cpu;
    assign o_gpu_handle = r_gpu;
    assign o_persistent_in_use     = r_p_use[8:0];
    assign o_persistent_high_water = r_p_hw[8:0];
    assign o_transient_in_use      = r_t_use[9:0];
    assign o_transient_high_water  = r_t_hw[9:0];
    assign o_exhaustion_count      = r_exh;

    `DSA_ASSERT_IMP(a_ready_idle, i_clk, i_rst_n, o_ready, !o_valid)
    `DSA_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_status))
    `DSA_ASSERT_IMP(a_fill_range, i_clk, i_rst_n, 1'b1, r_fill <= FC'(PERSISTENT_SLOTS))
    `DSA_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, w_acc_in, !o_ready)
endmodule
`default_nettype wire
